/* sv/rrb_pkg.sv */
package rrb_pkg;

  localparam int unsigned BUFFER_DEPTH = 1024;
  localparam int unsigned IDX_W = $clog2(BUFFER_DEPTH);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned FILL_W = 10;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned TMO_W = 32;

  localparam logic [TMO_W-1:0] GAP_TIMEOUT_RST = TMO_W'(5000);

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;
  localparam logic [1:0] CMD_DISCARD = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [FILL_W-1:0] fill_t;

  // bit 0 gap, bit 1 loss
  typedef struct packed {
    logic loss;
    logic gap;
  } tags_t;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    logic [7:0] wbyte;
    tags_t wtags;
    logic  re;
    idx_t  raddr;
  } mem_req_t;

  typedef struct packed {
    logic  pop_valid;
    logic  loss_force;
    fill_t fill;
  } res_info_t;

  function automatic idx_t next_slot(idx_t i);
    idx_t n;
    n = (i == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : i + 1'b1;
    return n;
  endfunction

  function automatic fill_t held_fill(idx_t w, idx_t r);
    logic [CNT_W-1:0] cnt;
    if (w >= r) begin
      cnt = CNT_W'(w) - CNT_W'(r);
    end else begin
      cnt = CNT_W'(BUFFER_DEPTH) - CNT_W'(r) + CNT_W'(w);
    end
    return FILL_W'(cnt);
  endfunction

endpackage

/* sv/rrb_store.sv */
module rrb_store (
  input  logic               clk,
  input  rrb_pkg::mem_req_t  req,
  output logic [7:0]         rd_byte,
  output rrb_pkg::tags_t     rd_tags
);

  logic [7:0]     byte_mem [rrb_pkg::BUFFER_DEPTH];
  rrb_pkg::tags_t flag_mem [rrb_pkg::BUFFER_DEPTH];
  logic [7:0]     rd_byte_r;
  rrb_pkg::tags_t rd_tags_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      byte_mem[req.waddr] <= req.wbyte;
      flag_mem[req.waddr] <= req.wtags;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_byte_r <= byte_mem[req.raddr];
      rd_tags_r <= flag_mem[req.raddr];
    end
  end

  assign rd_byte = rd_byte_r;
  assign rd_tags = rd_tags_r;

endmodule

/* sv/rrb_ctrl.sv */
module rrb_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic [1:0]                       cmd,
  input  logic [7:0]                       rx_byte,
  input  logic [rrb_pkg::TIME_W-1:0]       time_now_us,
  input  logic                             hw_fifo_had_bytes,
  input  logic                             cfg_wr_en,
  input  logic [rrb_pkg::TMO_W-1:0]        cfg_wr_data,
  output rrb_pkg::mem_req_t                mem_req,
  output rrb_pkg::res_info_t               res_info
);

  logic [rrb_pkg::TMO_W-1:0]  gap_timeout_r;
  rrb_pkg::idx_t              wr_idx_r, wr_idx_nxt;
  rrb_pkg::idx_t              rd_idx_r, rd_idx_nxt;
  logic [rrb_pkg::TIME_W-1:0] last_rx_r, last_rx_nxt;
  logic                       have_last_r, have_last_nxt;
  logic                       pend_loss_r, pend_loss_nxt;
  // head entry carries a loss tag set by an overwrite, held here instead of the memory
  logic                       head_loss_r, head_loss_nxt;
  logic [rrb_pkg::TIME_W-1:0] elapsed;
  logic                       is_empty;
  logic                       gap_hit;
  rrb_pkg::idx_t              wr_adv;
  logic                       pop_ok;

  assign elapsed  = time_now_us - last_rx_r;
  assign gap_hit  = have_last_r && (elapsed > rrb_pkg::TIME_W'(gap_timeout_r));
  assign is_empty = (wr_idx_r == rd_idx_r);
  assign wr_adv   = rrb_pkg::next_slot(wr_idx_r);

  always_comb begin
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    last_rx_nxt   = last_rx_r;
    have_last_nxt = have_last_r;
    pend_loss_nxt = pend_loss_r;
    head_loss_nxt = head_loss_r;
    pop_ok        = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = wr_idx_r;
    mem_req.wbyte = rx_byte;
    mem_req.wtags = '{loss: pend_loss_r, gap: gap_hit};
    mem_req.re    = 1'b0;
    mem_req.raddr = rd_idx_r;
    if (accept) begin
      unique case (cmd)
        rrb_pkg::CMD_PUSH: begin
          mem_req.we    = 1'b1;
          pend_loss_nxt = 1'b0;
          last_rx_nxt   = time_now_us;
          have_last_nxt = 1'b1;
          wr_idx_nxt    = wr_adv;
          if (wr_adv == rd_idx_r) begin
            rd_idx_nxt    = rrb_pkg::next_slot(rd_idx_r);
            head_loss_nxt = 1'b1;
          end
        end
        rrb_pkg::CMD_POP: begin
          if (!is_empty) begin
            pop_ok        = 1'b1;
            mem_req.re    = 1'b1;
            rd_idx_nxt    = rrb_pkg::next_slot(rd_idx_r);
            head_loss_nxt = 1'b0;
          end
        end
        rrb_pkg::CMD_FLUSH: begin
          wr_idx_nxt    = '0;
          rd_idx_nxt    = '0;
          last_rx_nxt   = '0;
          have_last_nxt = 1'b0;
          pend_loss_nxt = 1'b0;
          head_loss_nxt = 1'b0;
        end
        rrb_pkg::CMD_DISCARD: begin
          wr_idx_nxt    = '0;
          rd_idx_nxt    = '0;
          head_loss_nxt = 1'b0;
          if (!is_empty || hw_fifo_had_bytes) begin
            last_rx_nxt   = time_now_us;
            have_last_nxt = 1'b1;
            pend_loss_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res_info.pop_valid  = pop_ok;
  assign res_info.loss_force = head_loss_r;
  assign res_info.fill       = rrb_pkg::held_fill(wr_idx_nxt, rd_idx_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_timeout_r <= rrb_pkg::GAP_TIMEOUT_RST;
      wr_idx_r      <= '0;
      rd_idx_r      <= '0;
      last_rx_r     <= '0;
      have_last_r   <= 1'b0;
      pend_loss_r   <= 1'b0;
      head_loss_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        gap_timeout_r <= cfg_wr_data;
      end
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      last_rx_r   <= last_rx_nxt;
      have_last_r <= have_last_nxt;
      pend_loss_r <= pend_loss_nxt;
      head_loss_r <= head_loss_nxt;
    end
  end

endmodule

/* sv/rx_ring_buffer_gap_loss_tag.sv */
// receive ring buffer with per-byte gap and loss tags
// input channel: in_valid / in_stall with in_cmd (push, pop, flush, discard),
//   in_rx_byte, in_time_now_us and in_hw_fifo_had_bytes
// result channel: out_valid / out_stall, one result beat per input beat, in order;
//   out_fill_level is the byte count after the item, the other fields carry a pop
// cfg_wr_en / cfg_wr_data write the 32-bit gap timeout in microseconds
// the byte memory is read and the read stage register loads when an input beat is taken;
//   the output register loads from them when it is free of out_stall
// throughput: one item per cycle while in_stall is low; indices live in registers and
//   each item needs at most one memory write or one memory read
// when out_stall is held, the read stage and the output register fill and then
//   in_stall rises; nothing is dropped
// reset clears indices, timestamps, tags and sets the timeout to 5000; the byte
//   memory is not cleared and needs no clearing pass
module rx_ring_buffer_gap_loss_tag (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_cmd,
  input  logic [7:0]                         in_rx_byte,
  input  logic [rrb_pkg::TIME_W-1:0]         in_time_now_us,
  input  logic                               in_hw_fifo_had_bytes,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_pop_valid,
  output logic [7:0]                         out_data_byte,
  output logic                               out_gap_before,
  output logic                               out_data_loss,
  output logic [rrb_pkg::FILL_W-1:0]         out_fill_level,
  input  logic                               cfg_wr_en,
  input  logic [rrb_pkg::TMO_W-1:0]          cfg_wr_data
);

  rrb_pkg::mem_req_t  mem_req;
  rrb_pkg::res_info_t res_info;
  logic [7:0]         rd_byte;
  rrb_pkg::tags_t     rd_tags;
  logic               accept;
  logic               out_free;

  logic               s1_valid_r, s1_valid_nxt;
  rrb_pkg::res_info_t s1_info_r;

  logic               out_valid_r;
  logic               out_pop_valid_r;
  logic [7:0]         out_data_byte_r;
  logic               out_gap_r;
  logic               out_loss_r;
  rrb_pkg::fill_t     out_fill_r;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  rrb_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .cmd               (in_cmd),
    .rx_byte           (in_rx_byte),
    .time_now_us       (in_time_now_us),
    .hw_fifo_had_bytes (in_hw_fifo_had_bytes),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .mem_req           (mem_req),
    .res_info          (res_info)
  );

  rrb_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_byte (rd_byte),
    .rd_tags (rd_tags)
  );

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= res_info;
    end
    if (out_free) begin
      // read data only means something on a pop that found a byte
      out_pop_valid_r <= s1_info_r.pop_valid;
      out_data_byte_r <= s1_info_r.pop_valid ? rd_byte : 8'd0;
      out_gap_r       <= s1_info_r.pop_valid && rd_tags.gap;
      out_loss_r      <= s1_info_r.pop_valid && (rd_tags.loss || s1_info_r.loss_force);
      out_fill_r      <= s1_info_r.fill;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pop_valid  = out_pop_valid_r;
  assign out_data_byte  = out_data_byte_r;
  assign out_gap_before = out_gap_r;
  assign out_data_loss  = out_loss_r;
  assign out_fill_level = out_fill_r;

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r)
    else $error("read stage lost a beat while the output was blocked");

  a_no_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pop_valid |->
      out_data_byte == 8'd0 && !out_gap_before && !out_data_loss)
    else $error("result without a popped byte carries data");

  a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_cmd == rrb_pkg::CMD_FLUSH |=> s1_info_r.fill == '0)
    else $error("flush left bytes in the buffer");

  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("taken beat did not enter the read stage");

endmodule
